/* rtl/tlag_pkg.sv */
// Shared widths, constants and types of the tile layout address generator.
`default_nettype none

package tlag_pkg;

   // Limits applied to the configured display and grid sizes
   localparam int DISPLAY_DIM_MAX = 8192;
   localparam int GRID_DIM_MAX    = 16;
   localparam int CHANNEL_BITS    = 8;

   // Register widths
   localparam int DIM_W      = 14;
   localparam int GRID_W     = 5;
   localparam int BPP_W      = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 14;

   // Result field widths
   localparam int LEFT_W     = 13;
   localparam int TOP_OUT_W  = 21;
   localparam int SPAN_W     = 14;
   localparam int OFFSET_W   = 36;

   // Full top edge: row index times cell height
   localparam int TOP_W      = CHANNEL_BITS + DIM_W;

   // Pipeline depth
   localparam int DIV_STAGES = 4;
   localparam int NUM_STAGES = DIV_STAGES + 4;

   localparam int MIN_SPAN   = 2;

   // Stream payload widths
   localparam int REQ_DATA_W   = ((CHANNEL_BITS + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = LEFT_W + TOP_OUT_W + 2 * SPAN_W + OFFSET_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLUMNS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_PIXEL = 3'd4;

   typedef struct packed {
      logic [SPAN_W-1:0]    span_y;
      logic [SPAN_W-1:0]    span_x;
      logic [TOP_OUT_W-1:0] top;
      logic [LEFT_W-1:0]    left;
   } tile_geom_type;

endpackage

`default_nettype wire

/* rtl/tlag_div_pipe.sv */
// Pipelined restoring divider, a fixed number of quotient bits per stage.
`default_nettype none

module tlag_div_pipe #(
   parameter int DIVIDEND_W = 8,
   parameter int DIVISOR_W  = 5,
   parameter int STAGES     = 4
) (
   input  wire                   clock,
   input  wire  [STAGES-1:0]     stage_en,
   input  wire  [DIVIDEND_W-1:0] dividend,
   input  wire  [DIVISOR_W-1:0]  divisor,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);

   localparam int STEPS  = (DIVIDEND_W + STAGES - 1) / STAGES;
   localparam int WORK_W = STEPS * STAGES;

   // work_ff shifts dividend bits out at the top and quotient bits in at the bottom
   logic [DIVISOR_W-1:0] rem_ff  [STAGES];
   logic [WORK_W-1:0]    work_ff [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [DIVISOR_W-1:0] rem_src;
      logic [DIVISOR_W-1:0] rem_in;
      logic [WORK_W-1:0]    work_src;
      logic [WORK_W-1:0]    work_in;

      if (s == 0) begin : g_first
         assign rem_src  = '0;
         assign work_src = WORK_W'(dividend);
      end else begin : g_next
         assign rem_src  = rem_ff[s-1];
         assign work_src = work_ff[s-1];
      end

      always_comb begin
         logic [DIVISOR_W:0] trial;
         rem_in  = rem_src;
         work_in = work_src;
         trial   = '0;
         for (int i = 0; i < STEPS; i++) begin
            trial = {rem_in, work_in[WORK_W-1]};
            if (trial >= {1'b0, divisor}) begin
               rem_in  = DIVISOR_W'(trial - {1'b0, divisor});
               work_in = {work_in[WORK_W-2:0], 1'b1};
            end else begin
               rem_in  = trial[DIVISOR_W-1:0];
               work_in = {work_in[WORK_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[s]) begin
            rem_ff[s]  <= rem_in;
            work_ff[s] <= work_in;
         end
      end
   end

   assign quotient  = work_ff[STAGES-1][DIVIDEND_W-1:0];
   assign remainder = rem_ff[STAGES-1];

endmodule

`default_nettype wire

/* rtl/tlag_edge_calc.sv */
// Tile edges from cell position and size, then aligned spans.
`default_nettype none

module tlag_edge_calc (
   input  wire                              clock,
   input  wire  [1:0]                       stage_en,
   input  wire  [tlag_pkg::GRID_W-1:0]       col,
   input  wire  [tlag_pkg::CHANNEL_BITS-1:0] row,
   input  wire  [tlag_pkg::DIM_W-1:0]        cell_w,
   input  wire  [tlag_pkg::DIM_W-1:0]        cell_h,
   input  wire  [tlag_pkg::GRID_W-1:0]       cols,
   input  wire  [tlag_pkg::GRID_W-1:0]       rows,
   input  wire  [tlag_pkg::DIM_W-1:0]        disp_w,
   input  wire  [tlag_pkg::DIM_W-1:0]        disp_h,
   output logic [tlag_pkg::DIM_W-1:0]        left_pos,
   output logic [tlag_pkg::TOP_W-1:0]        top_pos,
   output tlag_pkg::tile_geom_type           geom
);

   localparam int DIM_W   = tlag_pkg::DIM_W;
   localparam int TOP_W   = tlag_pkg::TOP_W;
   localparam int XPROD_W = tlag_pkg::GRID_W + DIM_W;
   localparam int ROWCMP_W = (tlag_pkg::CHANNEL_BITS > tlag_pkg::GRID_W) ?
                             tlag_pkg::CHANNEL_BITS : tlag_pkg::GRID_W;

   logic [XPROD_W-1:0] left_prod;
   logic [XPROD_W-1:0] right_prod;
   logic [TOP_W-1:0]   top_prod;
   logic [TOP_W:0]     bottom_prod;
   logic               last_col;
   logic               last_row;

   logic [DIM_W-1:0]   left_in,   left_ff;
   logic [DIM_W-1:0]   right_in,  right_ff;
   logic [TOP_W-1:0]   top_in,    top_ff;
   logic [TOP_W-1:0]   bottom_in, bottom_ff;

   logic [DIM_W-1:0]   dx;
   logic [TOP_W-1:0]   dy;
   tlag_pkg::tile_geom_type geom_in, geom_ff;

   function automatic logic [tlag_pkg::GRID_W-1:0] GRID_W_M1(
      input logic [tlag_pkg::GRID_W-1:0] v
   );
      return v - tlag_pkg::GRID_W'(1);
   endfunction

   // Stage one: cell edges, left to a multiple of 4, top to an even line
   always_comb begin
      left_prod   = XPROD_W'(col) * XPROD_W'(cell_w);
      right_prod  = (XPROD_W'(col) + XPROD_W'(1)) * XPROD_W'(cell_w);
      top_prod    = TOP_W'(row) * TOP_W'(cell_h);
      bottom_prod = ((TOP_W + 1)'(row) + (TOP_W + 1)'(1)) * (TOP_W + 1)'(cell_h);
      last_col    = (col == GRID_W_M1(cols));
      last_row    = (ROWCMP_W'(row) == (ROWCMP_W'(rows) - ROWCMP_W'(1)));

      left_in  = {left_prod[DIM_W-1:2], 2'b00};
      right_in = last_col ? {disp_w[DIM_W-1:2], 2'b00} : {right_prod[DIM_W-1:2], 2'b00};
      top_in   = {top_prod[TOP_W-1:1], 1'b0};
      bottom_in = last_row ? TOP_W'({disp_h[DIM_W-1:1], 1'b0})
                           : {bottom_prod[TOP_W-1:1], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         left_ff   <= left_in;
         right_ff  <= right_in;
         top_ff    <= top_in;
         bottom_ff <= bottom_in;
      end
   end

   assign left_pos = left_ff;
   assign top_pos  = top_ff;

   // Stage two: spans, never below the minimum
   always_comb begin
      dx = (right_ff > left_ff) ? (right_ff - left_ff) : '0;
      dy = (bottom_ff > top_ff) ? (bottom_ff - top_ff) : '0;

      geom_in.left   = left_ff[tlag_pkg::LEFT_W-1:0];
      geom_in.top    = top_ff[tlag_pkg::TOP_OUT_W-1:0];
      geom_in.span_x = (dx < DIM_W'(tlag_pkg::MIN_SPAN)) ?
                       tlag_pkg::SPAN_W'(tlag_pkg::MIN_SPAN) : tlag_pkg::SPAN_W'(dx);
      geom_in.span_y = (dy < TOP_W'(tlag_pkg::MIN_SPAN)) ?
                       tlag_pkg::SPAN_W'(tlag_pkg::MIN_SPAN) : dy[tlag_pkg::SPAN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         geom_ff <= geom_in;
      end
   end

   assign geom = geom_ff;

endmodule

`default_nettype wire

/* rtl/tlag_offset_calc.sv */
// Framebuffer byte offset: top times pitch, plus left, times bytes per pixel.
`default_nettype none

module tlag_offset_calc (
   input  wire                          clock,
   input  wire  [2:0]                   stage_en,
   input  wire  [tlag_pkg::DIM_W-1:0]    left_pos,
   input  wire  [tlag_pkg::TOP_W-1:0]    top_pos,
   input  wire  [tlag_pkg::DIM_W-1:0]    disp_w,
   input  wire  [tlag_pkg::BPP_W-1:0]    bpp,
   output logic [tlag_pkg::OFFSET_W-1:0] frame_offset
);

   localparam int OFFSET_W = tlag_pkg::OFFSET_W;
   localparam int PROD_W   = tlag_pkg::TOP_W + tlag_pkg::DIM_W;
   localparam int SCALE_W  = OFFSET_W + tlag_pkg::BPP_W;

   logic [PROD_W-1:0]          prod_full;
   logic [OFFSET_W-1:0]        prod_ff;
   logic [tlag_pkg::DIM_W-1:0] left_ff;
   logic [OFFSET_W-1:0]        sum_in, sum_ff;
   logic [SCALE_W-1:0]         scaled;
   logic [OFFSET_W-1:0]        offset_ff;

   assign prod_full = PROD_W'(top_pos) * PROD_W'(disp_w);

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         prod_ff <= prod_full[OFFSET_W-1:0];
         left_ff <= left_pos;
      end
   end

   // Everything wraps modulo the offset width
   assign sum_in = prod_ff + OFFSET_W'(left_ff);

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         sum_ff <= sum_in;
      end
   end

   assign scaled = SCALE_W'(sum_ff) * SCALE_W'(bpp);

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         offset_ff <= scaled[OFFSET_W-1:0];
      end
   end

   assign frame_offset = offset_ff;

endmodule

`default_nettype wire

/* rtl/tile_layout_address_gen_core.sv */
// Top level of the tile layout address generator: registers, pipeline control, datapath.
//
//   Channel  Direction  Handshake              Contents
//   req_     in         req_tvalid/req_tready  channel index
//   rsp_     out        rsp_tvalid/rsp_tready  left, top, spans, byte offset
//   csr_     in         csr_wr_en              register index and write data
//
// One transaction per cycle while rsp_tready holds; the pipeline: four divider stages
// (two or four quotient bits each), edge products, spans with top times pitch,
// add of left, scale by bytes per pixel.
// Synchronous active-high reset empties the pipeline and loads register defaults.
// Each stage holds its transaction only while the next one is full and stalled,
// so bubbles close up and the input keeps flowing into empty stages while a result waits.
`default_nettype none

module tile_layout_address_gen_core (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [tlag_pkg::REQ_DATA_W-1:0]    req_tdata,   // [7:0] channel_index
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // [12:0] tile_left, [33:13] tile_top, [47:34] tile_span_x,
   // [61:48] tile_span_y, [97:62] frame_byte_offset
   output logic [tlag_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  wire                               csr_wr_en,
   input  wire  [tlag_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [tlag_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   localparam int DIM_W      = tlag_pkg::DIM_W;
   localparam int GRID_W     = tlag_pkg::GRID_W;
   localparam int BPP_W      = tlag_pkg::BPP_W;
   localparam int NUM_STAGES = tlag_pkg::NUM_STAGES;
   localparam int DIV_STAGES = tlag_pkg::DIV_STAGES;

   // Configuration registers
   logic [DIM_W-1:0]  width_ff;
   logic [DIM_W-1:0]  height_ff;
   logic [GRID_W-1:0] cols_ff;
   logic [GRID_W-1:0] rows_ff;
   logic [BPP_W-1:0]  bpp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(1920);
         height_ff <= DIM_W'(1080);
         cols_ff   <= GRID_W'(2);
         rows_ff   <= GRID_W'(2);
         bpp_ff    <= BPP_W'(3);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            tlag_pkg::CSR_DISPLAY_WIDTH:   width_ff  <= csr_wr_data[DIM_W-1:0];
            tlag_pkg::CSR_DISPLAY_HEIGHT:  height_ff <= csr_wr_data[DIM_W-1:0];
            tlag_pkg::CSR_GRID_COLUMNS:    cols_ff   <= csr_wr_data[GRID_W-1:0];
            tlag_pkg::CSR_GRID_ROWS:       rows_ff   <= csr_wr_data[GRID_W-1:0];
            tlag_pkg::CSR_BYTES_PER_PIXEL: bpp_ff    <= csr_wr_data[BPP_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective sizes: display clamped from above, grid counts to 1..max
   logic [DIM_W-1:0]  disp_w;
   logic [DIM_W-1:0]  disp_h;
   logic [GRID_W-1:0] cols;
   logic [GRID_W-1:0] rows;

   always_comb begin
      disp_w = (32'(width_ff) > tlag_pkg::DISPLAY_DIM_MAX) ?
               DIM_W'(tlag_pkg::DISPLAY_DIM_MAX) : width_ff;
      disp_h = (32'(height_ff) > tlag_pkg::DISPLAY_DIM_MAX) ?
               DIM_W'(tlag_pkg::DISPLAY_DIM_MAX) : height_ff;
      priority if (cols_ff == '0) begin
         cols = GRID_W'(1);
      end else if (32'(cols_ff) > tlag_pkg::GRID_DIM_MAX) begin
         cols = GRID_W'(tlag_pkg::GRID_DIM_MAX);
      end else begin
         cols = cols_ff;
      end
      priority if (rows_ff == '0) begin
         rows = GRID_W'(1);
      end else if (32'(rows_ff) > tlag_pkg::GRID_DIM_MAX) begin
         rows = GRID_W'(tlag_pkg::GRID_DIM_MAX);
      end else begin
         rows = rows_ff;
      end
   end

   // Pipeline control: a stage loads when empty or when the next one moves
   logic [NUM_STAGES-1:0] valid_in, valid_ff;
   logic [NUM_STAGES-1:0] stage_rdy;
   logic [NUM_STAGES-1:0] up_valid;
   logic [NUM_STAGES-1:0] stage_en;

   always_comb begin
      stage_rdy[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_tready;
      for (int s = NUM_STAGES - 2; s >= 0; s--) begin
         stage_rdy[s] = !valid_ff[s] || stage_rdy[s+1];
      end
      up_valid = {valid_ff[NUM_STAGES-2:0], req_tvalid};
      stage_en = stage_rdy & up_valid;
      valid_in = (valid_ff & ~stage_rdy) | (up_valid & stage_rdy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = stage_rdy[0];
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];

   // Column, row and cell sizes
   logic [tlag_pkg::CHANNEL_BITS-1:0] row;
   logic [GRID_W-1:0]                 col;
   logic [DIM_W-1:0]                  cell_w;
   logic [DIM_W-1:0]                  cell_h;

   tlag_div_pipe #(
      .DIVIDEND_W (tlag_pkg::CHANNEL_BITS),
      .DIVISOR_W  (GRID_W),
      .STAGES     (DIV_STAGES)
   ) u_index_div (
      .clock     (clock),
      .stage_en  (stage_en[DIV_STAGES-1:0]),
      .dividend  (req_tdata[tlag_pkg::CHANNEL_BITS-1:0]),
      .divisor   (cols),
      .quotient  (row),
      .remainder (col)
   );

   tlag_div_pipe #(
      .DIVIDEND_W (DIM_W),
      .DIVISOR_W  (GRID_W),
      .STAGES     (DIV_STAGES)
   ) u_width_div (
      .clock     (clock),
      .stage_en  (stage_en[DIV_STAGES-1:0]),
      .dividend  (disp_w),
      .divisor   (cols),
      .quotient  (cell_w),
      .remainder ()
   );

   tlag_div_pipe #(
      .DIVIDEND_W (DIM_W),
      .DIVISOR_W  (GRID_W),
      .STAGES     (DIV_STAGES)
   ) u_height_div (
      .clock     (clock),
      .stage_en  (stage_en[DIV_STAGES-1:0]),
      .dividend  (disp_h),
      .divisor   (rows),
      .quotient  (cell_h),
      .remainder ()
   );

   // Edges and spans
   logic [DIM_W-1:0]          left_pos;
   logic [tlag_pkg::TOP_W-1:0] top_pos;
   tlag_pkg::tile_geom_type   geom;

   tlag_edge_calc u_edge (
      .clock    (clock),
      .stage_en (stage_en[DIV_STAGES+1:DIV_STAGES]),
      .col      (col),
      .row      (row),
      .cell_w   (cell_w),
      .cell_h   (cell_h),
      .cols     (cols),
      .rows     (rows),
      .disp_w   (disp_w),
      .disp_h   (disp_h),
      .left_pos (left_pos),
      .top_pos  (top_pos),
      .geom     (geom)
   );

   // Byte offset
   logic [tlag_pkg::OFFSET_W-1:0] frame_offset;

   tlag_offset_calc u_offset (
      .clock        (clock),
      .stage_en     (stage_en[DIV_STAGES+3:DIV_STAGES+1]),
      .left_pos     (left_pos),
      .top_pos      (top_pos),
      .disp_w       (disp_w),
      .bpp          (bpp_ff),
      .frame_offset (frame_offset)
   );

   // Geometry follows the offset down its last two stages
   tlag_pkg::tile_geom_type geom_mid_ff;
   tlag_pkg::tile_geom_type geom_out_ff;

   always_ff @(posedge clock) begin
      if (stage_en[DIV_STAGES+2]) begin
         geom_mid_ff <= geom;
      end
      if (stage_en[DIV_STAGES+3]) begin
         geom_out_ff <= geom_mid_ff;
      end
   end

   assign rsp_tdata = tlag_pkg::RSP_DATA_W'({frame_offset,
                                             geom_out_ff.span_y,
                                             geom_out_ff.span_x,
                                             geom_out_ff.top,
                                             geom_out_ff.left});

endmodule

`default_nettype wire
